FILE: hdl/radix_digit_converter_macros.svh
// Assertion macros for the radix digit converter.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rdc_pkg.sv
// Shared types and constants for the radix digit converter.
// No dependencies.
package rdc_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned BASE_W  = 5;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_READ,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DEC_LIMIT) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else begin
      ch = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end
    return ch;
  endfunction

endpackage

FILE: hdl/radix_digit_converter.sv
// Radix digit converter: one input item gives D digits, MSB first.
// Valid base, nonzero number: each digit comes from the divider (S_DIV, S_STORE);
// S_READ and S_EMIT then give the digits in turn, held while out_ready_i is low.
// Bad base or zero: one digit, valid the cycle after accept. One item at a time.
// Reset clears the control state; the digit store is not cleared.
// Depends on rdc_pkg, rdc_serdiv and radix_digit_converter_macros.svh.
`include "radix_digit_converter_macros.svh"

module radix_digit_converter #(
  parameter int unsigned NUMBER_BITS = 31,
  parameter int unsigned MAX_DIGITS  = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [NUMBER_BITS-1:0]      number_i,
  input  logic [rdc_pkg::BASE_W-1:0]  base_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rdc_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                        last_o,
  output logic                        bad_base_o
);
  import rdc_pkg::*;

  localparam int unsigned BC_W  = $clog2(NUMBER_BITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam logic [BC_W-1:0]  BIT_TOP   = BC_W'(NUMBER_BITS - 1);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_DIGITS - 1);

  state_e               state_q, state_d;
  logic [BC_W-1:0]      bcnt_q, bcnt_d;
  logic [CNT_W-1:0]     dcount_q, dcount_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [BASE_W-1:0]    base_q;
  logic [DIGIT_W-1:0]   rd_q;
  logic                 last_q;
  logic                 bad_q;
  logic [DIGIT_W-1:0]   store_mem [MAX_DIGITS];

  div_ctrl_t              div_ctrl;
  logic [NUMBER_BITS-1:0] load_val;
  logic [NUMBER_BITS-1:0] quot;
  logic [DIGIT_W-1:0]     rem;

  logic in_accept;
  logic base_bad;
  logic num_zero;

  assign in_accept = in_valid_i && in_ready_o;
  assign base_bad  = (base_i < BASE_MIN) || (base_i > BASE_MAX);
  assign num_zero  = (number_i == '0);
  assign load_val  = (state_q == S_IDLE) ? number_i : quot;

  rdc_serdiv #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .ctrl_i    (div_ctrl),
    .load_val_i(load_val),
    .base_i    (base_q),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  always_comb begin
    state_d       = state_q;
    bcnt_d        = bcnt_q;
    dcount_d      = dcount_q;
    idx_d         = idx_q;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (base_bad || num_zero) begin
            state_d = S_EMIT;
          end else begin
            div_ctrl.load = 1'b1;
            bcnt_d        = BIT_TOP;
            dcount_d      = '0;
            state_d       = S_DIV;
          end
        end
      end
      S_DIV: begin
        div_ctrl.step = 1'b1;
        if (bcnt_q == '0) begin
          state_d = S_STORE;
        end else begin
          bcnt_d = bcnt_q - 1'b1;
        end
      end
      S_STORE: begin
        dcount_d = dcount_q + 1'b1;
        if ((quot == '0) || (dcount_q == LAST_SLOT)) begin
          idx_d   = dcount_q[IDX_W-1:0];
          state_d = S_READ;
        end else begin
          div_ctrl.load = 1'b1;
          bcnt_d        = BIT_TOP;
          state_d       = S_DIV;
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bcnt_q   <= '0;
      dcount_q <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      bcnt_q   <= bcnt_d;
      dcount_q <= dcount_d;
      idx_q    <= idx_d;
    end
  end

  // payload and digit store
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      base_q <= base_i;
      rd_q   <= '0;
      last_q <= 1'b1;
      bad_q  <= base_bad;
    end else if (state_q == S_READ) begin
      rd_q   <= store_mem[idx_q];
      last_q <= (idx_q == '0);
      bad_q  <= 1'b0;
    end
    if (state_q == S_STORE) begin
      store_mem[dcount_q[IDX_W-1:0]] <= rem;
    end
  end

  assign digit_char_o = ascii_of(rd_q);
  assign last_o       = last_q;
  assign bad_base_o   = bad_q;

  `RDC_ASSERT_NOW(a_bad_is_last, out_valid_o && bad_base_o, last_o, "bad base item not last")
  `RDC_ASSERT_NOW(a_one_at_a_time, in_ready_o, !out_valid_o, "input taken while emitting")
  `RDC_ASSERT_NOW(a_store_in_range, state_q == S_STORE, dcount_q <= LAST_SLOT,
                  "digit store overflow")
  `RDC_ASSERT_NEXT(a_last_frees, out_valid_o && out_ready_i && last_o, in_ready_o,
                   "not idle after last digit")

endmodule

FILE: hdl/rdc_serdiv.sv
// Bit-serial restoring divider by a small base (2..16).
// One quotient bit per cycle while ctrl_i.step is set, dividend shifted out MSB first. Uses rdc_pkg.
module rdc_serdiv #(
  parameter int unsigned NUMBER_BITS = 31
) (
  input  logic                          clk_i,
  input  rdc_pkg::div_ctrl_t            ctrl_i,
  input  logic [NUMBER_BITS-1:0]        load_val_i,
  input  logic [rdc_pkg::BASE_W-1:0]    base_i,
  output logic [NUMBER_BITS-1:0]        quot_o,
  output logic [rdc_pkg::DIGIT_W-1:0]   rem_o
);
  import rdc_pkg::*;

  logic [NUMBER_BITS-1:0] shreg_q, shreg_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [BASE_W-1:0]      trial;
  logic [BASE_W-1:0]      diff;
  logic                   qbit;

  assign trial = {rem_q, shreg_q[NUMBER_BITS-1]};
  assign qbit  = (trial >= base_i);
  assign diff  = trial - base_i;

  always_comb begin
    shreg_d = shreg_q;
    rem_d   = rem_q;
    if (ctrl_i.load) begin
      shreg_d = load_val_i;
      rem_d   = '0;
    end else if (ctrl_i.step) begin
      shreg_d = {shreg_q[NUMBER_BITS-2:0], qbit};
      rem_d   = qbit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
  end

  assign quot_o = shreg_q;
  assign rem_o  = rem_q;

endmodule
